FILE: rtl/core/tbl_pkg.sv
// shared types and constants for the token bucket limiter
// no dependencies; imported by tbl_mul, tbl_div and token_bucket_limiter
package tbl_pkg;

    // fixed field widths
    localparam int RATE_W  = 30;
    localparam int COST_W  = 32;
    localparam int CHUNK_W = 32;

    // nanoseconds per second, fits the rate width
    localparam logic [RATE_W-1:0] NS_PER_SEC = 30'd1000000000;

    // configuration register indexes
    typedef logic [0:0] cfg_idx_t;
    localparam cfg_idx_t REG_CAPACITY = 1'b0;
    localparam cfg_idx_t REG_RATE     = 1'b1;

endpackage

FILE: rtl/core/tbl_mul.sv
// chunked multiplier: A_WIDTH x RATE_W, one 32-bit chunk of a per cycle
// depends on tbl_pkg
module tbl_mul #(
    parameter int A_WIDTH = 64
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  logic [A_WIDTH-1:0]                     a,
    input  logic [tbl_pkg::RATE_W-1:0]             b,
    output logic                                   done,
    output logic [A_WIDTH+tbl_pkg::RATE_W-1:0]     product
);
    import tbl_pkg::*;

    localparam int NCH = A_WIDTH / CHUNK_W;
    localparam int PW  = A_WIDTH + RATE_W;
    localparam int CNT_W = $clog2(NCH + 1);

    logic [A_WIDTH-1:0] a_reg;
    logic [RATE_W-1:0]  b_reg;
    logic [PW-1:0]      acc_reg;
    logic [PW-1:0]      acc_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [CHUNK_W+RATE_W-1:0] part;

    // one partial product per cycle, most significant chunk first
    always_comb
    begin
        part     = a_reg[A_WIDTH-1 -: CHUNK_W] * b_reg;
        acc_next = (acc_reg << CHUNK_W) + PW'(part);
    end

    // control and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                a_reg    <= a;
                b_reg    <= b;
                acc_reg  <= '0;
                cnt_reg  <= CNT_W'(NCH);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                acc_reg <= acc_next;
                a_reg   <= a_reg << CHUNK_W;
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

FILE: rtl/core/tbl_div.sv
// restoring divider, two quotient bits per cycle, RATE_W-bit divisor
// depends on tbl_pkg
module tbl_div #(
    parameter int DVD_WIDTH = 94,
    parameter int QUO_WIDTH = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [DVD_WIDTH-1:0]        dividend,
    input  logic [tbl_pkg::RATE_W-1:0]  divisor,
    output logic                        done,
    output logic [QUO_WIDTH-1:0]        quotient
);
    import tbl_pkg::*;

    localparam int STEPS = QUO_WIDTH / 2;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic [RATE_W-1:0]    rem_reg;
    logic [RATE_W-1:0]    rem_next;
    logic [QUO_WIDTH-1:0] quo_reg;
    logic [QUO_WIDTH-1:0] quo_next;
    logic [RATE_W-1:0]    dvs_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    // two chained compare-subtract steps
    always_comb
    begin
        logic [RATE_W:0]   t1;
        logic [RATE_W:0]   t2;
        logic [RATE_W-1:0] r1;
        logic              ge1;
        logic              ge2;
        t1  = {rem_reg, quo_reg[QUO_WIDTH-1]};
        ge1 = (t1 >= {1'b0, dvs_reg});
        r1  = ge1 ? RATE_W'(t1 - {1'b0, dvs_reg}) : t1[RATE_W-1:0];
        t2  = {r1, quo_reg[QUO_WIDTH-2]};
        ge2 = (t2 >= {1'b0, dvs_reg});
        rem_next = ge2 ? RATE_W'(t2 - {1'b0, dvs_reg}) : t2[RATE_W-1:0];
        quo_next = {quo_reg[QUO_WIDTH-3:0], ge1, ge2};
    end

    // control and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                rem_reg  <= RATE_W'(dividend >> QUO_WIDTH);
                quo_reg  <= dividend[QUO_WIDTH-1:0];
                dvs_reg  <= divisor;
                cnt_reg  <= CNT_W'(STEPS);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                rem_reg <= rem_next;
                quo_reg <= quo_next;
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: rtl/core/token_bucket_limiter.sv
// token bucket rate limiter: top level with sequencer and bucket state
// depends on tbl_pkg, tbl_mul, tbl_div
//
//   channel   direction  handshake            payload
//   in        sink       in_valid / in_stall   now_time, cost
//   out       source     out_valid / out_stall granted, tokens_left
//   cfg       sink       cfg_valid / cfg_ready cfg_index, cfg_data
//
// a refilling request makes two passes each through the chunked multiplier
// and the 2-bit/cycle divider; only one when the first division yields no
// token, and none with no refill or for cost zero
// one request at a time; in_stall is high while a request is in flight
// the result sits in an output register, so a stalled output holds the next
// request only at its final step; reset empties the bucket, rate and time
module token_bucket_limiter #(
    parameter int COUNT_WIDTH = 32,
    parameter int TIME_WIDTH  = 63
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [TIME_WIDTH-1:0]         now_time,
    input  logic [tbl_pkg::COST_W-1:0]    cost,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          granted,
    output logic [COUNT_WIDTH-1:0]        tokens_left,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  tbl_pkg::cfg_idx_t             cfg_index,
    input  logic [((COUNT_WIDTH > tbl_pkg::RATE_W) ? COUNT_WIDTH : tbl_pkg::RATE_W)-1:0] cfg_data
);
    import tbl_pkg::*;

    localparam int AW  = TIME_WIDTH + 1;
    localparam int MA  = ((AW + CHUNK_W - 1) / CHUNK_W) * CHUNK_W;
    localparam int PW  = MA + RATE_W;
    localparam int DW  = TIME_WIDTH + RATE_W + 1;
    localparam int QW  = 2 * ((AW + 1) / 2);
    localparam int WW  = (COUNT_WIDTH > AW) ? COUNT_WIDTH : AW;
    localparam int GW  = (COUNT_WIDTH > COST_W) ? COUNT_WIDTH : COST_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL1,
        S_DIV1,
        S_MUL2,
        S_DIV2,
        S_GRANT,
        S_EMIT
    } state_t;

    state_t                  state_reg;
    logic [COUNT_WIDTH-1:0]  cap_reg;
    logic [RATE_W-1:0]       rate_reg;
    logic [COUNT_WIDTH-1:0]  tok_reg;
    logic [TIME_WIDTH-1:0]   last_time_reg;
    logic [TIME_WIDTH-1:0]   elapsed_reg;
    logic [AW-1:0]           added_reg;
    logic [COST_W-1:0]       cost_reg;
    logic                    ok_reg;
    logic                    out_valid_reg;
    logic                    granted_reg;
    logic [COUNT_WIDTH-1:0]  tokens_left_reg;
    logic                    mul_start_reg;
    logic                    div_start_reg;

    logic                    mul_done;
    logic [PW-1:0]           mul_product;
    logic [MA-1:0]           mul_a;
    logic [RATE_W-1:0]       mul_b;
    logic                    div_done;
    logic [QW-1:0]           div_quotient;
    logic [RATE_W-1:0]       div_divisor;
    logic                    in_accept;
    logic                    out_free;
    logic [COUNT_WIDTH-1:0]  tok_refilled;
    logic                    enough;

    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    // operand selection for the shared units
    assign mul_a       = (state_reg == S_MUL1) ? MA'(elapsed_reg) : MA'(added_reg);
    assign mul_b       = (state_reg == S_MUL1) ? rate_reg : NS_PER_SEC;
    assign div_divisor = (state_reg == S_DIV1) ? NS_PER_SEC : rate_reg;

    tbl_mul #(
        .A_WIDTH (MA)
    ) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start_reg),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_product)
    );

    tbl_div #(
        .DVD_WIDTH (DW),
        .QUO_WIDTH (QW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start_reg),
        .dividend (mul_product[DW-1:0]),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // saturating refill of the token count
    always_comb
    begin
        logic [WW-1:0] cap_w;
        logic [WW-1:0] tok_w;
        logic [WW-1:0] add_w;
        cap_w = WW'(cap_reg);
        tok_w = WW'(tok_reg);
        add_w = WW'(added_reg);
        if (tok_w >= cap_w)
            tok_refilled = cap_reg;
        else if (add_w >= cap_w - tok_w)
            tok_refilled = cap_reg;
        else
            tok_refilled = COUNT_WIDTH'(tok_w + add_w);
    end

    // enough tokens for the pending cost
    assign enough = (GW'(tok_reg) >= GW'(cost_reg));

    // sequencer, bucket state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cap_reg       <= '0;
            rate_reg      <= '0;
            tok_reg       <= '0;
            last_time_reg <= '0;
            out_valid_reg <= 1'b0;
            mul_start_reg <= 1'b0;
            div_start_reg <= 1'b0;
            ok_reg        <= 1'b0;
        end
        else
        begin
            mul_start_reg <= 1'b0;
            div_start_reg <= 1'b0;
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;

            // configuration write transaction
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_CAPACITY:
                    begin
                        cap_reg <= cfg_data[COUNT_WIDTH-1:0];
                        tok_reg <= cfg_data[COUNT_WIDTH-1:0];
                    end
                    REG_RATE:
                        rate_reg <= cfg_data[RATE_W-1:0];
                    default:
                        ;
                endcase
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        cost_reg <= cost;
                        if (cost == '0)
                        begin
                            ok_reg    <= 1'b1;
                            state_reg <= S_EMIT;
                        end
                        else if (rate_reg == '0 || now_time <= last_time_reg)
                            state_reg <= S_GRANT;
                        else
                        begin
                            elapsed_reg   <= now_time - last_time_reg;
                            mul_start_reg <= 1'b1;
                            state_reg     <= S_MUL1;
                        end
                    end
                end
                S_MUL1:
                begin
                    if (mul_done)
                    begin
                        div_start_reg <= 1'b1;
                        state_reg     <= S_DIV1;
                    end
                end
                S_DIV1:
                begin
                    if (div_done)
                    begin
                        if (div_quotient == '0)
                            state_reg <= S_GRANT;
                        else
                        begin
                            added_reg     <= div_quotient[AW-1:0];
                            mul_start_reg <= 1'b1;
                            state_reg     <= S_MUL2;
                        end
                    end
                end
                S_MUL2:
                begin
                    if (mul_done)
                    begin
                        div_start_reg <= 1'b1;
                        state_reg     <= S_DIV2;
                    end
                end
                S_DIV2:
                begin
                    // advance time only by what the whole tokens used
                    if (div_done)
                    begin
                        last_time_reg <= last_time_reg + div_quotient[TIME_WIDTH-1:0];
                        tok_reg       <= tok_refilled;
                        state_reg     <= S_GRANT;
                    end
                end
                S_GRANT:
                begin
                    ok_reg <= enough;
                    if (enough)
                        tok_reg <= tok_reg - COUNT_WIDTH'(cost_reg);
                    state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg   <= 1'b1;
                        granted_reg     <= ok_reg;
                        tokens_left_reg <= tok_reg;
                        state_reg       <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_stall    = (state_reg != S_IDLE);
    assign cfg_ready   = (state_reg == S_IDLE);
    assign out_valid   = out_valid_reg;
    assign granted     = granted_reg;
    assign tokens_left = tokens_left_reg;

endmodule
